// File: rtl/core/akoc_pkg.sv
// ----------------------------------------------------------------------------
// akoc_pkg: shared types and constants of the aging keyed object cache
// Holds the table geometry, the operation and status codes, the token that
// walks along the cell row and the write port that fills one cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package akoc_pkg;

    // Table geometry.
    localparam int ENTRIES      = 16;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_BITS     = 64;
    localparam int AGE_BITS     = 8;

    // Configuration port.
    localparam int            PADDR_W         = 3;
    localparam logic [7:0]    HOLD_COUNT_INIT = 8'd60;
    localparam logic          REG_HOLD_COUNT  = 1'b0;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        OP_FIND    = 2'd0,
        OP_INSERT  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Status codes of a result beat.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Control states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Request token that travels one cell per cycle.
    typedef struct packed {
        logic                    active;
        t_op                     op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    match;
        logic                    free_found;
        logic [IDX_W-1:0]        free_idx;
    } t_token;

    // Fill request for one cell after a successful insert.
    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        idx;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_cell_wr;

endpackage

`default_nettype wire

// File: rtl/core/akoc_cell.sv
// ----------------------------------------------------------------------------
// akoc_cell: one slot of the cache row
// Stores one entry (valid, key, payload, age), applies the passing request
// token to it and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module akoc_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [akoc_pkg::IDX_W-1:0] i_index,
    input  wire logic [7:0]            i_hold_count,
    input  wire akoc_pkg::t_token      i_tok,
    input  wire akoc_pkg::t_cell_wr    i_wr,
    output akoc_pkg::t_token           o_tok
);
    import akoc_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [AGE_BITS-1:0]     r_age;
    logic [AGE_BITS-1:0]     n_age;
    logic                    fill;
    logic                    match;
    t_token                  r_tok;
    t_token                  n_tok;

    assign fill  = i_wr.en && (i_wr.idx == i_index);
    assign match = i_tok.active && r_valid && (r_key == i_tok.key);

    // Apply the token to the stored entry and update the token.
    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        n_tok   = i_tok;
        if (i_tok.active) begin
            case (i_tok.op)
                OP_FIND: begin
                    if (match) begin
                        n_age         = '0;
                        n_tok.match   = 1'b1;
                        n_tok.payload = r_payload;
                    end else if (r_valid && (r_age != '0)) begin
                        n_age = r_age - 1'b1;
                        if (r_age == AGE_BITS'(1)) begin
                            n_valid = 1'b0;
                        end
                    end
                end
                OP_INSERT: begin
                    if (match) begin
                        n_tok.match = 1'b1;
                    end
                    if (!r_valid && !i_tok.free_found) begin
                        n_tok.free_found = 1'b1;
                        n_tok.free_idx   = i_index;
                    end
                end
                OP_RELEASE: begin
                    if (match) begin
                        n_age       = AGE_BITS'(i_hold_count);
                        n_tok.match = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
        // A fill never overlaps a token at this cell's table state.
        if (fill) begin
            n_valid = 1'b1;
            n_age   = '0;
        end
    end

    // Entry valid bit and the token handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    // Entry contents.
    always_ff @(posedge i_clk) begin
        r_age <= n_age;
        if (fill) begin
            r_key     <= i_wr.key;
            r_payload <= i_wr.payload;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/core/aging_keyed_object_cache.sv
// ----------------------------------------------------------------------------
// aging_keyed_object_cache: keyed object cache with deferred release aging
// A row of cells holds the table; each request walks the row as a token.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An accepted beat enters cell 0 at once
// and its token moves one cell per clock to the end of the row, where the
// finished token waits until the result register is free; a new beat is
// taken once that result is moved to the output register. Find matches the
// key in the cell the token is passing and ages the other entries on the
// way; insert collects the duplicate check and the lowest free slot and
// fills that slot at the end; release updates the matching cell and clear
// empties every cell as the token passes. The result register holds one
// finished beat while the next one is accepted.
// hold_count lies at byte address 0 of the APB port.
`timescale 1ns / 1ps
`default_nettype none

module aging_keyed_object_cache (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Request channel.
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [1:0]              i_opcode,
    input  wire logic [63:0]             i_lookup_key,
    input  wire logic [31:0]             i_new_payload,
    // Result channel.
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_hit,
    output logic [31:0]                  o_found_payload,
    output logic [1:0]                   o_status,
    // Configuration port.
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [akoc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import akoc_pkg::*;

    t_state   r_state;
    t_state   n_state;
    logic [7:0] r_hold_count;
    t_token   launch;
    t_token   tok [ENTRIES];
    t_token   r_done;
    t_cell_wr cell_wr;
    logic     done_take;
    logic     r_out_valid;
    logic     r_hit;
    logic [31:0] r_found;
    t_status  r_status;
    t_status  done_status;
    logic     done_hit;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_HOLD_COUNT) ? {24'd0, r_hold_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count <= HOLD_COUNT_INIT;
        end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_HOLD_COUNT)) begin
            r_hold_count <= pwdata[7:0];
        end
    end

    // Token entering the first cell.
    always_comb begin
        launch.active     = i_valid && o_ready;
        launch.op         = t_op'(i_opcode);
        launch.key        = i_lookup_key;
        launch.payload    = (t_op'(i_opcode) == OP_INSERT) ?
                            PAYLOAD_BITS'(i_new_payload) : '0;
        launch.match      = 1'b0;
        launch.free_found = 1'b0;
        launch.free_idx   = '0;
    end

    // Row of cells.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        akoc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(g)),
            .i_hold_count (r_hold_count),
            .i_tok        ((g == 0) ? launch : tok[(g == 0) ? 0 : g - 1]),
            .i_wr         (cell_wr),
            .o_tok        (tok[g])
        );
    end

    // Result of the finished token.
    always_comb begin
        done_hit    = (r_done.op == OP_FIND) && r_done.match;
        done_status = ST_OK;
        case (r_done.op)
            OP_INSERT: begin
                if (r_done.match) begin
                    done_status = ST_DUP;
                end else if (!r_done.free_found) begin
                    done_status = ST_FULL;
                end
            end
            OP_RELEASE: begin
                if (!r_done.match) begin
                    done_status = ST_MISSING;
                end
            end
            default: begin
                done_status = ST_OK;
            end
        endcase
    end

    // Sequencer: next state, handshakes and the insert fill.
    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        done_take = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok[ENTRIES-1].active) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    done_take = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        cell_wr.en      = done_take && (r_done.op == OP_INSERT) &&
                          !r_done.match && r_done.free_found;
        cell_wr.idx     = r_done.free_idx;
        cell_wr.key     = r_done.key;
        cell_wr.payload = r_done.payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Finished token waits here until the result register is free.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && tok[ENTRIES-1].active) begin
            r_done <= tok[ENTRIES-1];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_take) begin
            r_hit    <= done_hit;
            r_found  <= done_hit ? 32'(r_done.payload) : 32'd0;
            r_status <= done_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_found_payload = r_found;
    assign o_status        = r_status;

endmodule

`default_nettype wire

// File: tb/akoc_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akoc_reply_checker: reply predictor and scoreboard of the object cache
// Watches the request, result and APB channels at the rising clock edge. It
// keeps its own copy of the cache table and of hold_count, predicts the reply
// of every accepted request beat and compares each result beat field by
// field with the oldest prediction. It reports the failure count and the
// number of replies still owed to the testbench top.
// ----------------------------------------------------------------------------

module akoc_reply_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [63:0]                   i_lookup_key,
    input  logic [31:0]                   i_new_payload,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic                          o_hit,
    input  logic [31:0]                   o_found_payload,
    input  logic [1:0]                    o_status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [akoc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_outstanding
);

    import akoc_pkg::*;

    localparam logic [PADDR_W-1:0] HOLD_ADDR = PADDR_W'(4 * REG_HOLD_COUNT);

    typedef struct packed {
        logic                    hit;
        logic [PAYLOAD_BITS-1:0] payload;
        t_status                 status;
    } t_cache_reply;

    // Shadow copy of the cache table and of the hold_count register.
    logic                    tbl_valid   [ENTRIES];
    logic [KEY_BITS-1:0]     tbl_key     [ENTRIES];
    logic [PAYLOAD_BITS-1:0] tbl_payload [ENTRIES];
    logic [AGE_BITS-1:0]     tbl_age     [ENTRIES];
    logic [AGE_BITS-1:0]     hold;

    t_cache_reply pending_replies[$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Apply one request to the shadow table and work out the reply it causes.
    task automatic apply_request(input t_op op, input logic [KEY_BITS-1:0] key,
                                 input logic [31:0] pay, output t_cache_reply reply);
        int slot;
        int free_slot;
        reply.hit     = 1'b0;
        reply.payload = '0;
        reply.status  = ST_OK;
        slot          = -1;
        free_slot     = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_key[i] == key)
                slot = i;
            if (free_slot < 0 && !tbl_valid[i])
                free_slot = i;
        end
        case (op)
            OP_FIND: begin
                if (slot >= 0) begin
                    tbl_age[slot] = '0;
                    reply.hit     = 1'b1;
                    reply.payload = tbl_payload[slot];
                end
                // Every find ages the live table; an entry that runs out is freed.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_age[i] != 0) begin
                        tbl_age[i] = tbl_age[i] - 1'b1;
                        if (tbl_age[i] == 0)
                            tbl_valid[i] = 1'b0;
                    end
                end
            end
            OP_INSERT: begin
                // The duplicate check wins over the full check.
                if (slot >= 0) begin
                    reply.status = ST_DUP;
                end else if (free_slot < 0) begin
                    reply.status = ST_FULL;
                end else begin
                    tbl_valid[free_slot]   = 1'b1;
                    tbl_key[free_slot]     = key;
                    tbl_payload[free_slot] = pay[PAYLOAD_BITS-1:0];
                    tbl_age[free_slot]     = '0;
                end
            end
            OP_RELEASE: begin
                if (slot >= 0)
                    tbl_age[slot] = hold;
                else
                    reply.status = ST_MISSING;
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
            end
        endcase
    endtask

    // Sample all channels at the rising edge; results are retired before new
    // requests are predicted, so a stray result never pops a fresh prediction.
    always @(posedge i_clk) begin : watch
        t_cache_reply want;
        t_cache_reply fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                tbl_valid[i] = 1'b0;
            hold = HOLD_COUNT_INIT;
            pending_replies.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (pending_replies.size() == 0) begin
                    $error("result beat with no request pending: %s %0d %0d %0d",
                           "hit, payload, status", o_hit, o_found_payload, o_status);
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, o_hit);
                        o_fail_count++;
                    end
                    if (o_found_payload !== want.payload) begin
                        $error("found_payload: expected 0x%08h, actual 0x%08h",
                               want.payload, o_found_payload);
                        o_fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                apply_request(t_op'(i_opcode), i_lookup_key, i_new_payload, fresh);
                pending_replies.push_back(fresh);
            end
            // Register traffic: writes update the shadow, reads are checked.
            if (psel && penable && pready && paddr == HOLD_ADDR) begin
                if (pwrite) begin
                    hold = pwdata[AGE_BITS-1:0];
                end else if (prdata !== {{(32-AGE_BITS){1'b0}}, hold}) begin
                    $error("hold_count: expected %0d, actual %0d", hold, prdata);
                    o_fail_count++;
                end
            end
        end
        o_outstanding = pending_replies.size();
    end

endmodule

// File: tb/aging_keyed_object_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_keyed_object_cache_tb: testbench top of the aging keyed object cache
// Drives request beats through a directed sequence (empty table, fill to
// full, duplicate, missing release, release aging out) and then random
// phases under several hold_count settings, with random idle gaps on the
// request side and random stalls on the result side. The reply checker
// predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------

module aging_keyed_object_cache_tb;

    import akoc_pkg::*;

    localparam int                 POOL_SIZE   = ENTRIES + 8;
    localparam int                 PHASE_ITEMS = 130;
    localparam logic [PADDR_W-1:0] HOLD_ADDR   = PADDR_W'(4 * REG_HOLD_COUNT);
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = PADDR_W'(4 * (REG_HOLD_COUNT + 1));

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_opcode        = OP_FIND;
    logic [63:0]          i_lookup_key    = '0;
    logic [31:0]          i_new_payload   = '0;
    logic                 o_valid;
    logic                 i_ready         = 1'b0;
    logic                 o_hit;
    logic [31:0]          o_found_payload;
    logic [1:0]           o_status;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [PADDR_W-1:0]   paddr           = '0;
    logic [31:0]          pwdata          = '0;
    logic [31:0]          prdata;
    logic                 pready;
    int                   o_fail_count;
    int                   o_outstanding;

    // Idling switches, changed per phase so some phases run back to back.
    logic                 gaps_on   = 1'b1;
    logic                 stalls_on = 1'b1;
    logic [63:0]          key_pool [POOL_SIZE];

    aging_keyed_object_cache uut (.*);

    akoc_reply_checker reply_check (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    // Result side: random stalls of i_ready, updated at the falling edge.
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
                if (stalls_on && $urandom_range(99) < 25)
                    stall = idle_length();
            end
        end
    end

    // Present one request beat and hold it until it is accepted.
    // Called and returning at a falling edge.
    task automatic send_request(input t_op op, input logic [63:0] key,
                                input logic [31:0] pay);
        int idle_n;
        idle_n = (gaps_on && $urandom_range(99) < 40) ? idle_length() : 0;
        if (idle_n > 0) begin
            i_valid <= 1'b0;
            repeat (idle_n) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_lookup_key  <= key;
        i_new_payload <= pay;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // One APB transfer: setup phase, then access until pready.
    task automatic apb_transfer(input logic write, input logic [PADDR_W-1:0] addr,
                                input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write hold_count with junk in the unused upper bits, then read it back.
    task automatic set_hold_count(input logic [7:0] value);
        apb_transfer(1'b1, HOLD_ADDR, {24'($urandom_range(16777215)), value});
        apb_transfer(1'b0, HOLD_ADDR, '0);
    endtask

    // Stop sending and wait until every reply has come back.
    task automatic drain_replies();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (o_outstanding != 0)
            @(negedge i_clk);
    endtask

    // Random beat, mostly on pooled keys so finds hit and the table fills up.
    task automatic random_request();
        t_op         op;
        logic [63:0] key;
        logic [31:0] pay;
        int          r;
        r = $urandom_range(99);
        if (r < 45)
            op = OP_FIND;
        else if (r < 78)
            op = OP_INSERT;
        else if (r < 97)
            op = OP_RELEASE;
        else
            op = OP_CLEAR;
        if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            key = {$urandom, $urandom};
        r = $urandom_range(19);
        if (r == 0)
            pay = '0;
        else if (r == 1)
            pay = '1;
        else
            pay = $urandom;
        send_request(op, key, pay);
    endtask

    initial begin : stimulus
        logic [7:0] phase_hold [6];
        phase_hold = '{8'd255, 8'd0, 8'd1, 8'd7, 8'd60, 8'd3};
        phase_hold[4] = 8'($urandom_range(254, 2));

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default value first, then a short hold so the release ages out fast.
        apb_transfer(1'b0, HOLD_ADDR, '0);
        set_hold_count(8'd2);

        // Directed: empty table, fill it, then the full, duplicate and
        // missing-key cases, and a released entry aging out.
        send_request(OP_FIND, key_pool[0], '0);
        send_request(OP_INSERT, key_pool[0], '1);
        send_request(OP_INSERT, key_pool[1], '0);
        for (int i = 2; i < ENTRIES; i++)
            send_request(OP_INSERT, key_pool[i], $urandom);
        send_request(OP_INSERT, key_pool[ENTRIES], $urandom);
        send_request(OP_INSERT, key_pool[1], $urandom);
        send_request(OP_FIND, key_pool[1], $urandom);
        send_request(OP_RELEASE, key_pool[ENTRIES + 1], '0);
        send_request(OP_RELEASE, key_pool[0], '0);
        send_request(OP_FIND, key_pool[1], '0);
        send_request(OP_FIND, key_pool[1], '0);
        send_request(OP_FIND, key_pool[0], '0);
        send_request(OP_CLEAR, key_pool[2], $urandom);
        send_request(OP_FIND, key_pool[1], '0);
        drain_replies();

        // A write to an unmapped address must leave hold_count alone.
        apb_transfer(1'b1, SPARE_ADDR, 32'hFFFF_FFFF);
        apb_transfer(1'b0, HOLD_ADDR, '0);

        // Random phases under different hold counts and idling patterns.
        for (int p = 0; p < 6; p++) begin
            set_hold_count(phase_hold[p]);
            gaps_on   = (p % 3 != 1);
            stalls_on = (p % 3 != 2);
            if (p == 3) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            repeat (PHASE_ITEMS) random_request();
            drain_replies();
        end

        repeat (ENTRIES + 4) @(negedge i_clk);
        if (o_fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
